// ----- hw/rtl/sart_pkg.sv -----
// Shared types, codes and constants of the security association replay table.
package sart_pkg;

    localparam int ENTRIES_DEFAULT   = 16;
    localparam int KEY_BYTES_DEFAULT = 32;

    localparam logic [31:0] EDGE_BIT      = 32'h8000_0000;
    localparam logic [31:0] WIN_MAX_SHIFT = 32'd31;
    localparam logic [31:0] START_EDGE    = 32'd32;

    typedef enum logic [2:0] {
        CMD_ADD_KEY    = 3'd0,
        CMD_GET_KEY    = 3'd1,
        CMD_GET_SPI    = 3'd2,
        CMD_GET_REPLAY = 3'd3,
        CMD_MARK_SEQ   = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_ACCEPTED  = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] spi;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] seq_num;
        logic [7:0]  key_byte;
        logic        key_byte_valid;
        logic        key_last;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] spi_out;
        logic [31:0] window_right;
        logic [31:0] window_map;
        logic [7:0]  key_byte_out;
        logic [5:0]  key_length;
        logic        last_result;
    } result_t;

endpackage

// ----- hw/rtl/sart_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module sart_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/security_association_replay_table.sv -----
// Top level of the security association table with anti-replay windows.
// Add and unknown commands answer in the cycle after acceptance; busy stays low.
// Lookups scan the entry RAM in order, with a read and a compare state per entry,
// plus an action state on a hit; get key then reads each key byte through the key RAM.
// Reset clears the entry count and the pending key state; RAM contents are
// not cleared. The receiver cannot stall, so each result shows for one cycle.
module security_association_replay_table
    import sart_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEFAULT,
    parameter int KEY_BYTES = KEY_BYTES_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    localparam int EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int KLW = $clog2(KEY_BYTES + 1);
    localparam int KD  = ENTRIES * KEY_BYTES;
    localparam int KAW = (KD > 1) ? $clog2(KD) : 1;
    localparam int WD  = 160 + KLW;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN_RD  = 6'b000010,
        S_SCAN_CMP = 6'b000100,
        S_ACT      = 6'b001000,
        S_KEY_RD   = 6'b010000,
        S_KEY_OUT  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [KLW-1:0]     pend_reg, pend_next;
    logic               ovf_reg, ovf_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [KLW-1:0]     j_reg, j_next;
    request_t           req_reg, req_next;
    logic               done_reg, done_next;
    result_t            res_reg, res_next;

    logic               sa_we, sa_re;
    logic [EW-1:0]      sa_waddr;
    logic [WD-1:0]      sa_wdata, sa_rdata;
    logic               key_we, key_re;
    logic [KAW-1:0]     key_waddr, key_raddr;
    logic [7:0]         key_rdata;

    logic [31:0]        e_spi, e_src, e_dst, e_right, e_map;
    logic [KLW-1:0]     e_len;
    logic [KLW-1:0]     add_pend;
    logic               add_ovf;
    logic [31:0]        up_dist, down_dist, low_edge, new_right, new_map;
    logic [4:0]         shamt;

    assign e_spi   = sa_rdata[WD-1 -: 32];
    assign e_src   = sa_rdata[WD-33 -: 32];
    assign e_dst   = sa_rdata[WD-65 -: 32];
    assign e_right = sa_rdata[WD-97 -: 32];
    assign e_map   = sa_rdata[WD-129 -: 32];
    assign e_len   = sa_rdata[KLW-1:0];

    sart_ram #(.WIDTH(WD), .DEPTH(ENTRIES)) u_sa_ram (
        .clk   (clk),
        .we    (sa_we),
        .waddr (sa_waddr),
        .wdata (sa_wdata),
        .re    (sa_re),
        .raddr (idx_reg[EW-1:0]),
        .rdata (sa_rdata)
    );

    sart_ram #(.WIDTH(8), .DEPTH(KD)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (request.key_byte),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    assign add_ovf  = ovf_reg
                    | (request.key_byte_valid && pend_reg == KLW'(KEY_BYTES));
    assign add_pend = pend_reg + KLW'(request.key_byte_valid
                                      && pend_reg < KLW'(KEY_BYTES));
    assign key_waddr = KAW'(int'(count_reg) * KEY_BYTES + int'(pend_reg));
    assign key_raddr = KAW'(int'(idx_reg) * KEY_BYTES + int'(j_reg));

    assign up_dist   = req_reg.seq_num - e_right;
    assign down_dist = e_right - req_reg.seq_num;
    assign low_edge  = e_right - WIN_MAX_SHIFT;
    assign shamt     = (up_dist > WIN_MAX_SHIFT) ? 5'd31 : up_dist[4:0];

    always_comb
    begin
        new_right = e_right;
        new_map   = e_map;
        if (req_reg.seq_num > e_right)
        begin
            new_map   = (e_map >> shamt) | EDGE_BIT;
            new_right = req_reg.seq_num;
        end
        else if (req_reg.seq_num >= low_edge && down_dist <= WIN_MAX_SHIFT)
        begin
            new_map = e_map | (EDGE_BIT >> down_dist[4:0]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        j_next     = j_reg;
        req_next   = req_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        sa_we      = 1'b0;
        sa_re      = 1'b0;
        sa_waddr   = count_reg[EW-1:0];
        sa_wdata   = {request.spi, request.src_addr, request.dst_addr,
                      START_EDGE, 32'd0, add_pend};
        key_we     = 1'b0;
        key_re     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = request;
                    res_next = '0;
                    res_next.last_result = 1'b1;
                    case (request.cmd)
                        CMD_ADD_KEY:
                        begin
                            done_next = 1'b1;
                            key_we = request.key_byte_valid
                                   && pend_reg < KLW'(KEY_BYTES)
                                   && count_reg < CW'(ENTRIES);
                            pend_next = add_pend;
                            ovf_next  = add_ovf;
                            if (!request.key_last)
                            begin
                                res_next.status = ST_ACCEPTED;
                            end
                            else
                            begin
                                pend_next = '0;
                                ovf_next  = 1'b0;
                                if (count_reg >= CW'(ENTRIES))
                                begin
                                    res_next.status = ST_FULL;
                                end
                                else if (add_ovf)
                                begin
                                    res_next.status = ST_TOO_LONG;
                                end
                                else
                                begin
                                    sa_we = 1'b1;
                                    count_next = count_reg + CW'(1);
                                    res_next.status = ST_OK;
                                end
                            end
                        end
                        CMD_GET_KEY, CMD_GET_SPI, CMD_GET_REPLAY, CMD_MARK_SEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                                res_next.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            res_next.status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                sa_re      = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (e_src == req_reg.src_addr && e_dst == req_reg.dst_addr
                    && (req_reg.cmd == CMD_GET_SPI || e_spi == req_reg.spi))
                begin
                    state_next = S_ACT;
                end
                else if (idx_reg + CW'(1) == count_reg)
                begin
                    done_next = 1'b1;
                    res_next.status = ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_ACT:
            begin
                state_next = S_IDLE;
                res_next.status = ST_OK;
                case (req_reg.cmd)
                    CMD_GET_KEY:
                    begin
                        if (e_len == '0)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            j_next     = '0;
                            state_next = S_KEY_RD;
                        end
                    end
                    CMD_GET_SPI:
                    begin
                        done_next = 1'b1;
                        res_next.spi_out = e_spi;
                    end
                    CMD_GET_REPLAY:
                    begin
                        done_next = 1'b1;
                        res_next.window_right = e_right;
                        res_next.window_map   = e_map;
                    end
                    default:
                    begin
                        done_next = 1'b1;
                        sa_we     = 1'b1;
                        sa_waddr  = idx_reg[EW-1:0];
                        sa_wdata  = {e_spi, e_src, e_dst, new_right, new_map, e_len};
                        res_next.window_right = new_right;
                        res_next.window_map   = new_map;
                    end
                endcase
            end
            S_KEY_RD:
            begin
                key_re     = 1'b1;
                state_next = S_KEY_OUT;
            end
            S_KEY_OUT:
            begin
                done_next = 1'b1;
                res_next.status       = ST_OK;
                res_next.key_byte_out = key_rdata;
                res_next.key_length   = 6'(e_len);
                res_next.last_result  = (j_reg + KLW'(1) == e_len);
                j_next = j_reg + KLW'(1);
                if (j_reg + KLW'(1) == e_len)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_KEY_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= '0;
            ovf_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            ovf_reg   <= ovf_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        j_reg   <= j_next;
        req_reg <= req_next;
        res_reg <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- verif/sart_checker.sv -----
// Checker that predicts table results from observed transactions and compares them.
module sart_checker
    import sart_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  request_t request,
    input  logic     done,
    input  result_t  result,
    output int       fail_count,
    output int       pending_count,
    output int       result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NENT = ENTRIES_DEFAULT;
    localparam int NKEY = KEY_BYTES_DEFAULT;

    logic        sa_valid [NENT];
    logic [31:0] sa_spi [NENT];
    logic [31:0] sa_src [NENT];
    logic [31:0] sa_dst [NENT];
    logic [31:0] sa_right [NENT];
    logic [31:0] sa_map [NENT];
    logic [7:0]  sa_key [NENT*NKEY];
    logic [5:0]  sa_klen [NENT];
    int          sa_count;
    int          add_len;
    logic        add_overflow;
    result_t     expected_results [$];

    function automatic result_t blank(input logic [2:0] st);
        result_t r;
        r = '0;
        r.status = st;
        r.last_result = 1'b1;
        return r;
    endfunction

    task automatic queue_result(input result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    function automatic int lookup_sa(input logic use_spi, input request_t q);
        for (int i = 0; i < NENT; i++)
        begin
            if (sa_valid[i] && sa_src[i] == q.src_addr && sa_dst[i] == q.dst_addr
                && (!use_spi || sa_spi[i] == q.spi))
                return i;
        end
        return -1;
    endfunction

    task automatic predict_table(input request_t q);
        int      e;
        result_t r;
        logic [31:0] d;
        e = -1;
        case (q.cmd)
            CMD_ADD_KEY:
            begin
                if (q.key_byte_valid)
                begin
                    if (add_len < NKEY)
                    begin
                        if (sa_count < NENT)
                            sa_key[sa_count*NKEY + add_len] = q.key_byte;
                        add_len++;
                    end
                    else
                        add_overflow = 1'b1;
                end
                if (!q.key_last)
                    queue_result(blank(ST_ACCEPTED));
                else
                begin
                    if (sa_count >= NENT)
                        r = blank(ST_FULL);
                    else if (add_overflow)
                        r = blank(ST_TOO_LONG);
                    else
                    begin
                        sa_valid[sa_count] = 1'b1;
                        sa_spi[sa_count]   = q.spi;
                        sa_src[sa_count]   = q.src_addr;
                        sa_dst[sa_count]   = q.dst_addr;
                        sa_right[sa_count] = START_EDGE;
                        sa_map[sa_count]   = '0;
                        sa_klen[sa_count]  = 6'(add_len);
                        sa_count++;
                        r = blank(ST_OK);
                    end
                    add_len = 0;
                    add_overflow = 1'b0;
                    queue_result(r);
                end
            end
            CMD_GET_KEY:
            begin
                e = lookup_sa(1'b1, q);
                if (e < 0)
                    queue_result(blank(ST_NOT_FOUND));
                else if (sa_klen[e] == 0)
                    queue_result(blank(ST_OK));
                else
                    for (int i = 0; i < sa_klen[e]; i++)
                    begin
                        r = blank(ST_OK);
                        r.key_byte_out = sa_key[e*NKEY + i];
                        r.key_length = sa_klen[e];
                        r.last_result = (i + 1 == sa_klen[e]);
                        queue_result(r);
                    end
            end
            CMD_GET_SPI:
            begin
                e = lookup_sa(1'b0, q);
                r = blank(e < 0 ? ST_NOT_FOUND : ST_OK);
                if (e >= 0)
                    r.spi_out = sa_spi[e];
                queue_result(r);
            end
            CMD_GET_REPLAY, CMD_MARK_SEQ:
            begin
                e = lookup_sa(1'b1, q);
                if (e < 0)
                    queue_result(blank(ST_NOT_FOUND));
                else
                begin
                    if (q.cmd == CMD_MARK_SEQ)
                    begin
                        if (q.seq_num > sa_right[e])
                        begin
                            d = q.seq_num - sa_right[e];
                            if (d > WIN_MAX_SHIFT)
                                d = WIN_MAX_SHIFT;
                            sa_map[e] = (sa_map[e] >> d) | EDGE_BIT;
                            sa_right[e] = q.seq_num;
                        end
                        else if (q.seq_num >= sa_right[e] - WIN_MAX_SHIFT)
                        begin
                            d = sa_right[e] - q.seq_num;
                            if (d <= WIN_MAX_SHIFT)
                                sa_map[e] |= EDGE_BIT >> d;
                        end
                    end
                    r = blank(ST_OK);
                    r.window_right = sa_right[e];
                    r.window_map = sa_map[e];
                    queue_result(r);
                end
            end
            default:
                queue_result(blank(ST_NOT_FOUND));
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t x;
        if (!rst_n)
        begin
            for (int i = 0; i < NENT; i++)
                sa_valid[i] = 1'b0;
            sa_count = 0;
            add_len = 0;
            add_overflow = 1'b0;
            expected_results.delete();
            fail_count = 0;
            result_count = 0;
        end
        else
        begin
            if (done)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result %h", result);
                end
                else
                begin
                    x = expected_results.pop_front();
                    if (result !== x)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected %h, actual %h", x, result);
                    end
                end
            end
            if (start && !busy)
                predict_table(request);
        end
        pending_count = expected_results.size();
    end
endmodule

// ----- verif/tb_top.sv -----
// Testbench top: stimulus, clock, reset and verdict for the replay table.
module tb_top;
    import sart_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    logic     done;
    request_t request = '0;
    result_t  result;
    int       fail_count;
    int       pending_count;
    int       result_count;
    int       cycle_count = 0;
    int       sent_count = 0;
    logic [31:0] addr_pool [4];
    logic [31:0] spi_pool [4];

    security_association_replay_table u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .request(request), .done(done), .result(result)
    );

    sart_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .fail_count(fail_count),
        .pending_count(pending_count), .result_count(result_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send(input request_t q);
        request <= q;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if (n > 0)
        begin
            start <= 1'b0;
            request <= '0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic random_fields(ref request_t q, input logic known);
        int k;
        q.cmd = 3'($urandom);
        q.spi = $urandom;
        q.src_addr = $urandom;
        q.dst_addr = $urandom;
        q.seq_num = $urandom;
        q.key_byte = 8'($urandom);
        q.key_byte_valid = 1'($urandom);
        q.key_last = 1'($urandom);
        k = $urandom_range(0, 3);
        if (known)
        begin
            q.spi = spi_pool[k];
            q.src_addr = addr_pool[k];
            q.dst_addr = addr_pool[3 - k];
        end
    endtask

    task automatic add_entry(input int nbytes, input int k, input logic empty_flag);
        request_t q;
        for (int i = 0; i < nbytes; i++)
        begin
            random_fields(q, 1'b0);
            q.cmd = CMD_ADD_KEY;
            q.key_byte_valid = ($urandom_range(0, 7) != 0);
            q.key_last = 1'b0;
            send(q);
            if ($urandom_range(0, 3) == 0)
                idle_gap();
        end
        random_fields(q, 1'b0);
        q.cmd = CMD_ADD_KEY;
        q.spi = spi_pool[k];
        q.src_addr = addr_pool[k];
        q.dst_addr = addr_pool[3 - k];
        q.key_byte_valid = ~empty_flag;
        q.key_last = 1'b1;
        send(q);
    endtask

    initial
    begin
        request_t q;
        int k;
        for (int i = 0; i < 4; i++)
        begin
            addr_pool[i] = $urandom;
            spi_pool[i] = $urandom;
        end
        addr_pool[0] = '1;
        spi_pool[1] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_entry(0, 0, 1'b1);
        add_entry(2, 1, 1'b0);
        add_entry(48, 2, 1'b0);
        for (int c = CMD_GET_KEY; c <= 7; c++)
        begin
            random_fields(q, 1'b1);
            q.cmd = 3'(c);
            q.spi = spi_pool[0];
            q.src_addr = addr_pool[0];
            q.dst_addr = addr_pool[3];
            q.seq_num = '1;
            send(q);
        end
        random_fields(q, 1'b0);
        q.cmd = CMD_GET_KEY;
        send(q);
        add_entry(31, 3, 1'b0);
        add_entry(1, 2, 1'b0);
        for (int i = 0; i < 12; i++)
            add_entry(0, i % 4, 1'b0);

        while (sent_count < 210)
        begin
            idle_gap();
            k = $urandom_range(0, 9);
            if (k < 2)
                add_entry($urandom_range(0, 3) == 0 ? $urandom_range(28, 34)
                          : $urandom_range(0, 4), $urandom_range(0, 3), 1'b0);
            else
            begin
                random_fields(q, $urandom_range(0, 7) != 0);
                q.cmd = (k < 8) ? CMD_MARK_SEQ : 3'($urandom_range(1, 7));
                if ($urandom_range(0, 3) != 0)
                    q.seq_num = 32'd32 + $urandom_range(0, 120);
                send(q);
            end
        end
        start <= 1'b0;
        request <= '0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Sent %0d transactions and checked %0d results.", sent_count, result_count);
        $display("Covered adds up to overflow and table full, key reads, lookups and marks.");
        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
